// File: hw/rtl/rpv_pkg.sv
// shared types and constants for the rule pattern vote classifier
// no dependencies
package rpv_pkg;

    localparam int NUM_PATTERNS = 64;
    localparam int MAX_LITERALS = 8;
    localparam int NUM_ATTRS    = 32;
    localparam int NUM_CLASSES  = 8;

    localparam int PAT_W   = $clog2(NUM_PATTERNS);
    localparam int SLOT_W  = $clog2(MAX_LITERALS);
    localparam int LADDR_W = PAT_W + SLOT_W;
    localparam int ATTR_W  = $clog2(NUM_ATTRS);
    localparam int CLS_W   = $clog2(NUM_CLASSES);
    localparam int SCORE_W = 24;
    localparam int VAL_W   = 16;

    localparam int HDR_W = 4 + 2 * CLS_W + VAL_W;
    localparam int LIT_W = ATTR_W + 1 + VAL_W;

    localparam logic [1:0] MODE_HDR = 2'd0;
    localparam logic [1:0] MODE_LIT = 2'd1;
    localparam logic [1:0] MODE_OBS = 2'd2;

    localparam logic [1:0] CFG_CLASS_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PATTERN_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_HWAIT,
        ST_LWAIT,
        ST_OWAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                clear;
        logic                add;
        logic [CLS_W-1:0]    pos;
        logic [CLS_W-1:0]    neg;
        logic [VAL_W-1:0]    weight;
    } t_vote;

    typedef struct packed {
        logic             load;
        logic [CLS_W-1:0] idx;
        logic             last;
    } t_emit;

endpackage

// File: hw/rtl/rpv_ram.sv
// generic single write port ram with registered read
// no dependencies
module rpv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rpv_score.sv
// class score registers, winner tracking and result output register
// depends on rpv_pkg
module rpv_score import rpv_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_vote                     i_vote,
    input  t_emit                     i_emit,
    output logic                      o_free,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [CLS_W-1:0]          o_class_index,
    output logic signed [SCORE_W-1:0] o_class_score,
    output logic [CLS_W-1:0]          o_winner_class,
    output logic                      o_winner_found,
    output logic                      o_last
);

    logic signed [SCORE_W-1:0] r_score [NUM_CLASSES];
    logic signed [SCORE_W-1:0] n_score [NUM_CLASSES];
    logic signed [SCORE_W-1:0] r_best, n_best;
    logic [CLS_W-1:0]          r_win, n_win;
    logic                      r_found, n_found;
    logic                      r_valid;
    logic [CLS_W-1:0]          r_idx;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [CLS_W-1:0]          r_out_win;
    logic                      r_out_found;
    logic                      r_last;
    logic signed [SCORE_W-1:0] s_sel;
    logic signed [SCORE_W-1:0] s_w;

    assign s_w   = $signed({{(SCORE_W - VAL_W){1'b0}}, i_vote.weight});
    assign s_sel = r_score[i_emit.idx];
    assign o_free = !r_valid || i_ready;

    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n_score[c] = r_score[c];
            if (i_vote.clear) begin
                n_score[c] = '0;
            end else if (i_vote.add) begin
                if (i_vote.pos == CLS_W'(c)) n_score[c] = n_score[c] + s_w;
                if (i_vote.neg == CLS_W'(c)) n_score[c] = n_score[c] - s_w;
            end
        end
    end

    always_comb begin
        n_best  = r_best;
        n_win   = r_win;
        n_found = r_found;
        if (i_vote.clear) begin
            n_best  = '0;
            n_win   = '0;
            n_found = 1'b0;
        end else if (i_emit.load && s_sel > 0 && s_sel > r_best) begin
            n_best  = s_sel;
            n_win   = i_emit.idx;
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            r_score[c] <= n_score[c];
        end
        r_best  <= n_best;
        r_win   <= n_win;
        r_found <= n_found;
        if (i_emit.load) begin
            r_idx       <= i_emit.idx;
            r_out_score <= s_sel;
            r_out_win   <= i_emit.last && n_found ? n_win : '0;
            r_out_found <= i_emit.last && n_found;
            r_last      <= i_emit.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid        = r_valid;
    assign o_class_index  = r_idx;
    assign o_class_score  = r_out_score;
    assign o_winner_class = r_out_win;
    assign o_winner_found = r_out_found;
    assign o_last         = r_last;

endmodule

// File: hw/rtl/rpv_ctrl.sv
// classification sequencer: walks headers, literals and attributes in the rams
// depends on rpv_pkg
module rpv_ctrl import rpv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [PAT_W:0]     i_np,
    input  logic [CLS_W:0]     i_nc,
    output logic               o_idle,
    output logic [PAT_W-1:0]   o_hdr_raddr,
    input  logic [HDR_W-1:0]   i_hdr_rdata,
    output logic [LADDR_W-1:0] o_lit_raddr,
    input  logic [LIT_W-1:0]   i_lit_rdata,
    output logic [ATTR_W-1:0]  o_obs_raddr,
    input  logic [VAL_W-1:0]   i_obs_rdata,
    input  logic               i_out_free,
    output t_vote              o_vote,
    output t_emit              o_emit
);

    t_state               r_state, n_state;
    logic [PAT_W:0]       r_p, n_p;
    logic [SLOT_W-1:0]    r_k, n_k;
    logic [CLS_W-1:0]     r_c, n_c;
    logic [HDR_W-1:0]     r_hdr, n_hdr;
    logic                 r_dir, n_dir;
    logic signed [VAL_W-1:0] r_thr, n_thr;
    logic signed [VAL_W-1:0] s_attr;
    logic                 s_pass;
    logic                 s_lastk;
    logic                 s_lastc;

    assign s_attr  = $signed(i_obs_rdata);
    assign s_pass  = r_dir ? (s_attr < r_thr) : (s_attr > r_thr);
    assign s_lastk = ({1'b0, r_k} + 4'd1) == r_hdr[HDR_W-1 -: 4];
    assign s_lastc = ({1'b0, r_c} + 1'b1) == i_nc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_HDR;
            ST_HDR:   n_state = (r_p >= i_np) ? ST_EMIT : ST_HWAIT;
            ST_HWAIT: n_state = (i_hdr_rdata[HDR_W-1 -: 4] == 4'd0) ? ST_HDR : ST_LWAIT;
            ST_LWAIT: n_state = ST_OWAIT;
            ST_OWAIT: n_state = (!s_pass || s_lastk) ? ST_HDR : ST_LWAIT;
            ST_EMIT:  if (i_out_free && s_lastc) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_p   = r_p;
        n_k   = r_k;
        n_c   = r_c;
        n_hdr = r_hdr;
        n_dir = r_dir;
        n_thr = r_thr;
        o_hdr_raddr = r_p[PAT_W-1:0];
        o_lit_raddr = {r_p[PAT_W-1:0], r_k};
        o_obs_raddr = i_lit_rdata[LIT_W-1 -: ATTR_W];
        o_vote = '{clear: 1'b0, add: 1'b0, pos: r_hdr[2*CLS_W+VAL_W-1 -: CLS_W],
                   neg: r_hdr[CLS_W+VAL_W-1 -: CLS_W], weight: r_hdr[VAL_W-1:0]};
        o_emit = '{load: 1'b0, idx: r_c, last: s_lastc};
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_vote.clear = 1'b1;
                    n_p = '0;
                end
            end
            ST_HDR: begin
                n_c = '0;
            end
            ST_HWAIT: begin
                n_hdr = i_hdr_rdata;
                n_k   = '0;
                if (i_hdr_rdata[HDR_W-1 -: 4] == 4'd0) begin
                    o_vote.add    = 1'b1;
                    o_vote.pos    = i_hdr_rdata[2*CLS_W+VAL_W-1 -: CLS_W];
                    o_vote.neg    = i_hdr_rdata[CLS_W+VAL_W-1 -: CLS_W];
                    o_vote.weight = i_hdr_rdata[VAL_W-1:0];
                    n_p = r_p + 1'b1;
                end
                o_lit_raddr = {r_p[PAT_W-1:0], {SLOT_W{1'b0}}};
            end
            ST_LWAIT: begin
                n_dir = i_lit_rdata[VAL_W];
                n_thr = $signed(i_lit_rdata[VAL_W-1:0]);
            end
            ST_OWAIT: begin
                if (!s_pass) begin
                    n_p = r_p + 1'b1;
                end else if (s_lastk) begin
                    o_vote.add = 1'b1;
                    n_p = r_p + 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                    o_lit_raddr = {r_p[PAT_W-1:0], n_k};
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    o_emit.load = 1'b1;
                    n_c = r_c + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_p     <= '0;
            r_k     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_k     <= n_k;
            r_c     <= n_c;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_dir <= n_dir;
        r_thr <= n_thr;
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule

// File: hw/rtl/rule_pattern_vote_classifier_top.sv
// top level of the rule pattern vote classifier: stream ports, config, rams
// depends on rpv_pkg, rpv_ram, rpv_ctrl, rpv_score
//
// Header, literal and non-final attribute transactions are accepted whenever the sequencer
// is idle. The transaction flagged tlast on an attribute starts classification: for every
// active pattern the sequencer reads its header and then each literal followed by its
// attribute, stopping at the first literal that fails, then emits one result per class
// while the output is taken. Scores live in registers; headers, literals and attributes sit
// in three rams with registered read. Input is not accepted while a run is busy.
module rule_pattern_vote_classifier_top import rpv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // pattern_index, literal_slot, literal_count, positive_class, negative_class,
    // weight, attribute_index, direction, threshold, attr_value, zero fill
    input  logic [79:0] s_axis_tdata,
    // mode
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // class_index, class_score, winner_class, winner_found, zero fill
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    logic [3:0]          r_class_count;
    logic [6:0]          r_pattern_count;
    logic [CLS_W:0]      s_nc;
    logic [PAT_W:0]      s_np;
    logic                s_idle;
    logic                s_acc;
    logic [1:0]          s_mode;
    logic [PAT_W-1:0]    s_pi;
    logic [SLOT_W-1:0]   s_slot;
    logic [3:0]          s_lc, s_lc_sat;
    logic [HDR_W-1:0]    s_hdr_w;
    logic [LIT_W-1:0]    s_lit_w;
    logic [PAT_W-1:0]    s_hdr_raddr;
    logic [HDR_W-1:0]    s_hdr_rdata;
    logic [LADDR_W-1:0]  s_lit_raddr;
    logic [LIT_W-1:0]    s_lit_rdata;
    logic [ATTR_W-1:0]   s_obs_raddr;
    logic [VAL_W-1:0]    s_obs_rdata;
    logic                s_free;
    t_vote               s_vote;
    t_emit               s_emit;
    logic [CLS_W-1:0]    s_ci, s_wc;
    logic signed [SCORE_W-1:0] s_score;
    logic                s_wf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count   <= 4'd8;
            r_pattern_count <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_CLASS_COUNT)   r_class_count   <= i_cfg_data[3:0];
            if (i_cfg_index == CFG_PATTERN_COUNT) r_pattern_count <= i_cfg_data;
        end
    end

    assign s_nc = (r_class_count == 4'd0) ? (CLS_W+1)'(1) :
                  (r_class_count > 4'(NUM_CLASSES)) ? (CLS_W+1)'(NUM_CLASSES) :
                  r_class_count[CLS_W:0];
    assign s_np = (r_pattern_count > 7'(NUM_PATTERNS)) ? (PAT_W+1)'(NUM_PATTERNS) :
                  r_pattern_count[PAT_W:0];

    assign s_axis_tready = s_idle;
    assign s_acc  = s_axis_tvalid && s_idle;
    assign s_mode = s_axis_tuser;
    assign s_pi   = s_axis_tdata[5:0];
    assign s_slot = s_axis_tdata[8:6];
    assign s_lc   = s_axis_tdata[12:9];
    assign s_lc_sat = (s_lc > 4'(MAX_LITERALS)) ? 4'(MAX_LITERALS) : s_lc;
    assign s_hdr_w = {s_lc_sat, s_axis_tdata[15:13], s_axis_tdata[18:16], s_axis_tdata[34:19]};
    assign s_lit_w = {s_axis_tdata[39:35], s_axis_tdata[40], s_axis_tdata[56:41]};

    rpv_ram #(.WIDTH(HDR_W), .DEPTH(NUM_PATTERNS)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && s_mode == MODE_HDR),
        .i_waddr (s_pi),
        .i_wdata (s_hdr_w),
        .i_raddr (s_hdr_raddr),
        .o_rdata (s_hdr_rdata)
    );

    rpv_ram #(.WIDTH(LIT_W), .DEPTH(NUM_PATTERNS * MAX_LITERALS)) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && s_mode == MODE_LIT),
        .i_waddr ({s_pi, s_slot}),
        .i_wdata (s_lit_w),
        .i_raddr (s_lit_raddr),
        .o_rdata (s_lit_rdata)
    );

    rpv_ram #(.WIDTH(VAL_W), .DEPTH(NUM_ATTRS)) u_obs_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc && s_mode == MODE_OBS),
        .i_waddr (s_axis_tdata[39:35]),
        .i_wdata (s_axis_tdata[72:57]),
        .i_raddr (s_obs_raddr),
        .o_rdata (s_obs_rdata)
    );

    rpv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_acc && s_mode == MODE_OBS && s_axis_tlast),
        .i_np        (s_np),
        .i_nc        (s_nc),
        .o_idle      (s_idle),
        .o_hdr_raddr (s_hdr_raddr),
        .i_hdr_rdata (s_hdr_rdata),
        .o_lit_raddr (s_lit_raddr),
        .i_lit_rdata (s_lit_rdata),
        .o_obs_raddr (s_obs_raddr),
        .i_obs_rdata (s_obs_rdata),
        .i_out_free  (s_free),
        .o_vote      (s_vote),
        .o_emit      (s_emit)
    );

    rpv_score u_score (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_vote         (s_vote),
        .i_emit         (s_emit),
        .o_free         (s_free),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_class_index  (s_ci),
        .o_class_score  (s_score),
        .o_winner_class (s_wc),
        .o_winner_found (s_wf),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, s_wf, s_wc, s_score, s_ci};

endmodule

// File: test/tb_rule_pattern_vote_classifier_top.sv
// testbench for rule_pattern_vote_classifier_top: loads rule patterns, streams observations
// and checks every class score and winner against an in-bench vote predictor
// depends on rpv_pkg and the rtl of the classifier
`timescale 1ns / 1ps

module tb_rule_pattern_vote_classifier_top;
    import rpv_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]  mode;
        logic [5:0]  pat;
        logic [2:0]  slot;
        logic [3:0]  lcnt;
        logic [2:0]  pos;
        logic [2:0]  neg;
        logic [15:0] weight;
        logic [4:0]  attr;
        logic        dir;
        logic [15:0] thr;
        logic [15:0] val;
        logic        last;
    } t_item;

    typedef struct {
        logic [2:0]  cls;
        logic [23:0] score;
        logic [2:0]  wcls;
        logic        wfound;
        logic        last;
    } t_score;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [6:0]  i_cfg_data;

    rule_pattern_vote_classifier_top dut (.*);

    // predictor state
    logic [3:0]  pr_lcnt [NUM_PATTERNS];
    logic [2:0]  pr_pos [NUM_PATTERNS];
    logic [2:0]  pr_neg [NUM_PATTERNS];
    logic [15:0] pr_weight [NUM_PATTERNS];
    logic [4:0]  pr_lattr [NUM_PATTERNS*MAX_LITERALS];
    logic        pr_ldir [NUM_PATTERNS*MAX_LITERALS];
    logic [15:0] pr_lthr [NUM_PATTERNS*MAX_LITERALS];
    logic [15:0] pr_obs [NUM_ATTRS];
    logic [3:0]  pr_class_count;
    logic [6:0]  pr_pattern_count;

    // what the stimulus has already defined
    bit hdr_def [NUM_PATTERNS];
    bit lit_def [NUM_PATTERNS*MAX_LITERALS];

    t_item  pending_items[$];
    t_score expected_scores[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     send_gap = 0;
    int     recv_gap = 0;
    bit     no_gaps = 0;
    bit     any_xfer;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_q88();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4, 5: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit literal_holds(int idx);
        logic signed [15:0] a;
        logic signed [15:0] t;
        a = pr_obs[pr_lattr[idx]];
        t = pr_lthr[idx];
        return pr_ldir[idx] ? (a < t) : (a > t);
    endfunction

    task automatic predict_votes();
        int nc, np, win, best;
        int sc [NUM_CLASSES];
        bit found, hit;
        t_score r;
        nc = (pr_class_count == 0) ? 1 : (pr_class_count > NUM_CLASSES ? NUM_CLASSES
                                                                     : pr_class_count);
        np = (pr_pattern_count > NUM_PATTERNS) ? NUM_PATTERNS : pr_pattern_count;
        foreach (sc[c]) sc[c] = 0;
        for (int p = 0; p < np; p++) begin
            hit = 1;
            for (int k = 0; k < pr_lcnt[p]; k++)
                if (!literal_holds(p*MAX_LITERALS + k)) hit = 0;
            if (hit) begin
                sc[pr_pos[p]] += pr_weight[p];
                sc[pr_neg[p]] -= pr_weight[p];
            end
        end
        best = 0;
        win = 0;
        found = 0;
        for (int c = 0; c < nc; c++) begin
            if (sc[c] > 8388607) sc[c] = 8388607;
            if (sc[c] < -8388608) sc[c] = -8388608;
            if (sc[c] > best) begin
                best = sc[c];
                win = c;
                found = 1;
            end
        end
        for (int c = 0; c < nc; c++) begin
            r.cls = 3'(c);
            r.score = sc[c][23:0];
            r.last = (c == nc - 1);
            r.wcls = r.last ? win[2:0] : 3'd0;
            r.wfound = r.last & found;
            expected_scores.insert(expected_scores.size(), r);
        end
    endtask

    task automatic apply_item(t_item it);
        int li;
        li = it.pat * MAX_LITERALS + it.slot;
        case (it.mode)
            MODE_HDR: begin
                pr_lcnt[it.pat] = (it.lcnt > MAX_LITERALS) ? 4'(MAX_LITERALS) : it.lcnt;
                pr_pos[it.pat] = it.pos;
                pr_neg[it.pat] = it.neg;
                pr_weight[it.pat] = it.weight;
            end
            MODE_LIT: begin
                pr_lattr[li] = it.attr;
                pr_ldir[li] = it.dir;
                pr_lthr[li] = it.thr;
            end
            MODE_OBS: begin
                pr_obs[it.attr] = it.val;
                if (it.last) predict_votes();
            end
            default: ;
        endcase
    endtask

    // stimulus helpers
    function automatic t_item noise_item(logic [1:0] mode);
        t_item it;
        it.mode = mode;
        it.pat = 6'($urandom);
        it.slot = 3'($urandom);
        it.lcnt = 4'($urandom);
        it.pos = 3'($urandom);
        it.neg = 3'($urandom);
        it.weight = 16'($urandom);
        it.attr = 5'($urandom);
        it.dir = 1'($urandom);
        it.thr = 16'($urandom);
        it.val = 16'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    task automatic push_lit(int p, int s, int a, bit d, logic [15:0] t);
        t_item it;
        it = noise_item(MODE_LIT);
        it.pat = 6'(p);
        it.slot = 3'(s);
        it.attr = 5'(a);
        it.dir = d;
        it.thr = t;
        pending_items.insert(pending_items.size(), it);
        lit_def[p*MAX_LITERALS + s] = 1;
    endtask

    task automatic push_hdr(int p, int n, int ps, int ng, logic [15:0] w);
        t_item it;
        it = noise_item(MODE_HDR);
        it.pat = 6'(p);
        it.lcnt = 4'(n);
        it.pos = 3'(ps);
        it.neg = 3'(ng);
        it.weight = w;
        pending_items.insert(pending_items.size(), it);
        hdr_def[p] = 1;
        for (int s = 0; s < n && s < MAX_LITERALS; s++)
            if (!lit_def[p*MAX_LITERALS + s])
                push_lit(p, s, $urandom_range(NUM_ATTRS-1), 1'($urandom), pick_q88());
    endtask

    task automatic push_attr(int a, logic [15:0] v, bit last);
        t_item it;
        it = noise_item(MODE_OBS);
        it.attr = 5'(a);
        it.val = v;
        it.last = last;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic int pick_lcnt();
        return ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(3);
    endfunction

    task automatic define_upto(int n);
        for (int p = 0; p < n && p < NUM_PATTERNS; p++)
            if (!hdr_def[p])
                push_hdr(p, pick_lcnt(), $urandom_range(7), $urandom_range(7), pick_q88());
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_scores.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == CFG_CLASS_COUNT) pr_class_count = val[3:0];
        else pr_pattern_count = val;
        @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int r, k;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 65) begin
                k = $urandom_range(0, 4);
                repeat (k) push_attr($urandom_range(NUM_ATTRS-1), pick_q88(), 0);
                push_attr($urandom_range(NUM_ATTRS-1), pick_q88(), 1);
            end else if (r < 80) begin
                push_hdr($urandom_range(NUM_PATTERNS-1), pick_lcnt(), $urandom_range(7),
                         $urandom_range(7), pick_q88());
            end else if (r < 93) begin
                push_lit($urandom_range(NUM_PATTERNS-1), $urandom_range(MAX_LITERALS-1),
                         $urandom_range(NUM_ATTRS-1), 1'($urandom), pick_q88());
            end else begin
                pending_items.insert(pending_items.size(), noise_item(MODE_NONE));
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
            send_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_axis_tvalid <= 0;
            end else if (pending_items.size() != 0) begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1;
                s_axis_tuser <= it.mode;
                s_axis_tlast <= it.last;
                s_axis_tdata <= {7'd0, it.val, it.thr, it.dir, it.attr, it.weight, it.neg,
                                 it.pos, it.lcnt, it.slot, it.pat};
                send_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 0;
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
            recv_gap <= 0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= 1;
            if (m_axis_tvalid && m_axis_tready) recv_gap <= pick_gap();
        end
    end

    // input prediction, result checking and watchdog
    always @(posedge i_clk) begin
        t_item it;
        t_score e;
        if (i_rst_n) begin
            any_xfer = 0;
            if (s_axis_tvalid && s_axis_tready) begin
                any_xfer = 1;
                it.mode = s_axis_tuser;
                it.last = s_axis_tlast;
                {it.val, it.thr, it.dir, it.attr, it.weight, it.neg, it.pos, it.lcnt,
                 it.slot, it.pat} = s_axis_tdata[72:0];
                apply_item(it);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                any_xfer = 1;
                if (expected_scores.size() == 0) begin
                    $display("%0t: unexpected result, actual %h last %b", $realtime,
                             m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    e = expected_scores.pop_front();
                    if (m_axis_tdata[30:0] != {e.wfound, e.wcls, e.score, e.cls} ||
                        m_axis_tlast != e.last) begin
                        $display("%0t: mismatch, expected cls %0d score %h win %0d/%b last %b,",
                                 $realtime, e.cls, e.score, e.wcls, e.wfound, e.last,
                                 " actual cls %0d score %h win %0d/%b last %b",
                                 m_axis_tdata[2:0], m_axis_tdata[26:3], m_axis_tdata[29:27],
                                 m_axis_tdata[30], m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) any_xfer = 1;
            idle_cycles = any_xfer ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL rule_pattern_vote_classifier_top");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_CLASS_COUNT;
        i_cfg_data = '0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_HDR;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        pr_class_count = 4'd8;
        pr_pattern_count = '0;
        foreach (pr_obs[a]) pr_obs[a] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty pattern, saturated literal count, same class, ties, equality
        write_reg(CFG_CLASS_COUNT, 7'd8);
        write_reg(CFG_PATTERN_COUNT, 7'd4);
        push_hdr(0, 0, 2, 5, 16'h0100);
        push_hdr(1, 15, 7, 0, 16'hffff);
        push_lit(1, 0, 31, 0, 16'h8000);
        push_hdr(2, 1, 3, 3, 16'h8000);
        push_lit(2, 0, 2, 0, 16'h0000);
        push_hdr(3, 2, 4, 6, 16'h0100);
        push_lit(3, 0, 0, 0, 16'h8000);
        push_lit(3, 1, 1, 1, 16'h7fff);
        pending_items.insert(pending_items.size(), noise_item(MODE_NONE));
        for (int a = 0; a < NUM_ATTRS; a++)
            push_attr(a, a == 0 ? 16'h7fff : a == 1 ? 16'h8000 : a == 2 ? 16'h0000
                                                                       : pick_q88(),
                      a == NUM_ATTRS - 1);
        push_attr(0, 16'h8000, 1);
        push_attr(2, 16'h0001, 1);
        wait_idle();

        // a phase with no gaps in the sender and no receiver stalls
        no_gaps = 1;
        write_reg(CFG_CLASS_COUNT, 7'd1);
        write_reg(CFG_PATTERN_COUNT, 7'd8);
        define_upto(8);
        random_phase(4);
        wait_idle();
        no_gaps = 0;

        write_reg(CFG_CLASS_COUNT, 7'd0);
        write_reg(CFG_PATTERN_COUNT, 7'd20);
        define_upto(20);
        random_phase(4);
        wait_idle();

        write_reg(CFG_CLASS_COUNT, 7'd3);
        write_reg(CFG_PATTERN_COUNT, 7'd64);
        define_upto(64);
        random_phase(5);
        wait_idle();

        write_reg(CFG_CLASS_COUNT, 7'h7f);
        write_reg(CFG_PATTERN_COUNT, 7'h7f);
        random_phase(5);
        wait_idle();

        write_reg(CFG_CLASS_COUNT, 7'd5);
        write_reg(CFG_PATTERN_COUNT, 7'd0);
        random_phase(3);
        wait_idle();

        write_reg(CFG_CLASS_COUNT, 7'd8);
        write_reg(CFG_PATTERN_COUNT, 7'd12);
        random_phase(5);
        wait_idle();
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("PASS rule_pattern_vote_classifier_top");
        else
            $display("FAIL rule_pattern_vote_classifier_top");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rpv_pkg.sv
hw/rtl/rpv_ram.sv
hw/rtl/rpv_score.sv
hw/rtl/rpv_ctrl.sv
hw/rtl/rule_pattern_vote_classifier_top.sv
test/tb_rule_pattern_vote_classifier_top.sv
